### sv/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types and constants for the layer blend with opacity pipeline.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WeightW = 9;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // pipeline depth from accept to result strobe
  localparam int unsigned NumStages = 5;

  localparam logic [WeightW-1:0] FullWeight = 9'd256;

  // rounded divide by 255: q = ((x + 127) * Recip255) >> RecipShift,
  // exact for x + 127 below 132626
  localparam logic [17:0] Div255Bias = 18'd127;
  localparam logic [17:0] Recip255   = 18'd131587;
  localparam int unsigned RecipShift = 25;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_DIFF     = 3'd4
  } blend_mode_e;

  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_OPACITY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [WeightW-1:0] opacity;
  } cfg_t;

  // load of the first stage and valid bits of the stages behind it
  typedef struct packed {
    logic                 load;
    logic [NumStages-2:0] vld;
  } pipe_ctrl_t;

endpackage

### sv/pbm_cfg.sv
// ----------------------------------------------------------------------------
// pbm_cfg
// Register file behind the APB port: blend mode and opacity weight.
// ----------------------------------------------------------------------------
module pbm_cfg import pbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic               wr_en;
  reg_idx_e           reg_idx;
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [WeightW-1:0] opacity_q, opacity_d;
  logic [WeightW-1:0] wr_weight;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // next register values, opacity saturates at full weight
  always_comb begin
    mode_d    = mode_q;
    opacity_d = opacity_q;
    wr_weight = pwdata[WeightW-1:0];
    if (wr_en) begin
      case (reg_idx)
        REG_MODE: begin
          mode_d = pwdata[ModeW-1:0];
        end
        REG_OPACITY: begin
          opacity_d = (wr_weight > FullWeight) ? FullWeight : wr_weight;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      opacity_q <= FullWeight;
    end else begin
      mode_q    <= mode_d;
      opacity_q <= opacity_d;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = {{(DataW-ModeW){1'b0}}, mode_q};
      REG_OPACITY: prdata = {{(DataW-WeightW){1'b0}}, opacity_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = '{mode: mode_q, opacity: opacity_q};

  // weight never leaves the Q1.8 range 0 to 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    opacity_q <= FullWeight)
    else $error("opacity register above full weight");

  // oversized opacity writes land on full weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && reg_idx == REG_OPACITY && pwdata[WeightW-1:0] > FullWeight
    |=> opacity_q == FullWeight)
    else $error("opacity write not saturated");

endmodule

### sv/pbm_lane.sv
// ----------------------------------------------------------------------------
// pbm_lane
// One color channel: operand select, product, divide by 255, opacity mix.
// ----------------------------------------------------------------------------
module pbm_lane import pbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pipe_ctrl_t       ctrl_i,
  input  cfg_t             cfg_i,
  input  logic [ChanW-1:0] a_i,
  input  logic [ChanW-1:0] b_i,
  output logic [ChanW-1:0] out_o
);

  // stage 1 operand select
  logic [ChanW-1:0]   x1_d, y1_d, alt1_d;
  logic               dbl1_d, inv1_d, use1_d;
  logic [ChanW-1:0]   a1_q, x1_q, y1_q, alt1_q;
  logic               dbl1_q, inv1_q, use1_q;
  logic [WeightW-1:0] w1_q;

  // stage 2 product
  logic [15:0]        prod2;
  logic [16:0]        p2_d, p2_q;
  logic [ChanW-1:0]   a2_q, alt2_q;
  logic               inv2_q, use2_q;
  logic [WeightW-1:0] w2_q;

  // stage 3 divide by 255
  logic [17:0]        biased3;
  logic [35:0]        recip3;
  logic [ChanW-1:0]   q3_q, a3_q, alt3_q;
  logic               inv3_q, use3_q;
  logic [WeightW-1:0] w3_q;

  // stage 4 weighted difference
  logic [ChanW-1:0]   f4;
  logic signed [8:0]  diff4;
  logic signed [18:0] m4_d, m4_q;
  logic [ChanW-1:0]   a4_q;
  logic [WeightW-1:0] w4_q;

  // stage 5 mix and round
  logic signed [19:0] sum5;
  logic [ChanW-1:0]   out_q;

  // pick multiplier operands per mode, complements give 255 - v
  always_comb begin
    x1_d   = a_i;
    y1_d   = b_i;
    alt1_d = a_i;
    dbl1_d = 1'b0;
    inv1_d = 1'b0;
    use1_d = 1'b0;
    case (cfg_i.mode)
      MODE_NORMAL: begin
        alt1_d = b_i;
      end
      MODE_MULTIPLY: begin
        use1_d = 1'b1;
      end
      MODE_SCREEN: begin
        x1_d   = ~a_i;
        y1_d   = ~b_i;
        inv1_d = 1'b1;
        use1_d = 1'b1;
      end
      MODE_OVERLAY: begin
        use1_d = 1'b1;
        dbl1_d = 1'b1;
        if (a_i[ChanW-1]) begin
          x1_d   = ~a_i;
          y1_d   = ~b_i;
          inv1_d = 1'b1;
        end
      end
      MODE_DIFF: begin
        alt1_d = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
      end
      default: begin
        alt1_d = a_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a1_q   <= a_i;
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      alt1_q <= alt1_d;
      dbl1_q <= dbl1_d;
      inv1_q <= inv1_d;
      use1_q <= use1_d;
      w1_q   <= cfg_i.opacity;
    end
  end

  // 8x8 product, doubled for overlay
  assign prod2 = x1_q * y1_q;
  assign p2_d  = dbl1_q ? {prod2, 1'b0} : {1'b0, prod2};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld[0]) begin
      p2_q   <= p2_d;
      a2_q   <= a1_q;
      alt2_q <= alt1_q;
      inv2_q <= inv1_q;
      use2_q <= use1_q;
      w2_q   <= w1_q;
    end
  end

  // rounded divide by 255 through a reciprocal multiply
  assign biased3 = {1'b0, p2_q} + Div255Bias;
  assign recip3  = biased3 * Recip255;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld[1]) begin
      q3_q   <= recip3[RecipShift+ChanW-1:RecipShift];
      a3_q   <= a2_q;
      alt3_q <= alt2_q;
      inv3_q <= inv2_q;
      use3_q <= use2_q;
      w3_q   <= w2_q;
    end
  end

  // blended value, then weight times (blend - base)
  assign f4    = use3_q ? (inv3_q ? ~q3_q : q3_q) : alt3_q;
  assign diff4 = $signed({1'b0, f4}) - $signed({1'b0, a3_q});
  assign m4_d  = $signed({1'b0, w3_q}) * diff4;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld[2]) begin
      m4_q <= m4_d;
      a4_q <= a3_q;
      w4_q <= w3_q;
    end
  end

  // base * 256 + weighted difference + half, keep the integer part
  assign sum5 = $signed({4'b0000, a4_q, 8'h80}) + $signed({m4_q[18], m4_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld[3]) begin
      out_q <= sum5[15:8];
    end
  end

  assign out_o = out_q;

  // zero weight passes the base channel through untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[3] && w4_q == '0 |=> out_q == $past(a4_q))
    else $error("zero opacity did not pass base through");

endmodule

### sv/pixel_blend_modes_opacity_top.sv
// A pixel passes the operand, product, divide, weight and mix registers,
// then shows on the result ports for one cycle with out_valid_o high.
// Throughput: one pixel per cycle; busy stays low and the five-stage lane
// pipeline (product multiplier, reciprocal multiplier, weight multiplier)
// takes a new word every cycle.
// Reset: clears the stage valid bits, mode to normal and opacity to 256.
// ----------------------------------------------------------------------------
// pixel_blend_modes_opacity_top
// Blends a top layer pixel onto a base pixel by mode, then mixes with opacity.
// ----------------------------------------------------------------------------
module pixel_blend_modes_opacity_top import pbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command side
  input  logic             start,
  output logic             busy,
  input  logic [ChanW-1:0] base_red_i,
  input  logic [ChanW-1:0] base_green_i,
  input  logic [ChanW-1:0] base_blue_i,
  input  logic [ChanW-1:0] top_red_i,
  input  logic [ChanW-1:0] top_green_i,
  input  logic [ChanW-1:0] top_blue_i,
  // result side
  output logic             out_valid_o,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic                 accept;
  logic [NumStages-1:0] vld_q, vld_d;
  pipe_ctrl_t           ctrl;
  cfg_t                 cfg;

  // register file
  pbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a word is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits shift along with the data
  assign vld_d = {vld_q[NumStages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl = '{load: accept, vld: vld_q[NumStages-2:0]};

  // one lane per channel
  pbm_lane u_lane_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .a_i    (base_red_i),
    .b_i    (top_red_i),
    .out_o  (out_red_o)
  );

  pbm_lane u_lane_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .a_i    (base_green_i),
    .b_i    (top_green_i),
    .out_o  (out_green_o)
  );

  pbm_lane u_lane_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .a_i    (base_blue_i),
    .b_i    (top_blue_i),
    .out_o  (out_blue_o)
  );

  assign out_valid_o = vld_q[NumStages-1];

  // every result strobe traces back to an earlier accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, 5))
    else $error("result strobe without matching accept");

endmodule

### tb/pbm_blend_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbm_blend_checker
// Watches the register port, the pixel command side and the result side of
// the blend block. Keeps its own copy of mode and opacity, predicts every
// blended pixel and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module pbm_blend_checker import pbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command side
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [ChanW-1:0] base_red_i,
  input  logic [ChanW-1:0] base_green_i,
  input  logic [ChanW-1:0] base_blue_i,
  input  logic [ChanW-1:0] top_red_i,
  input  logic [ChanW-1:0] top_green_i,
  input  logic [ChanW-1:0] top_blue_i,
  // result side
  input  logic             out_valid_i,
  input  logic [ChanW-1:0] out_red_i,
  input  logic [ChanW-1:0] out_green_i,
  input  logic [ChanW-1:0] out_blue_i,
  // register port
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic             pready_i,
  // status to the testbench top
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  logic [ModeW-1:0]   cur_mode;
  logic [WeightW-1:0] cur_opacity;
  pixel_t             blended_px_q[$];
  int                 result_idx;

  // rounded divide by 255, never a tie
  function automatic int unsigned round_div255(input int unsigned x);
    return (x + 127) / 255;
  endfunction

  // blended value of one channel before the opacity mix
  function automatic int unsigned mode_blend(input logic [ModeW-1:0] mode,
                                             input int unsigned a,
                                             input int unsigned b);
    case (mode)
      MODE_NORMAL:   return b;
      MODE_MULTIPLY: return round_div255(a * b);
      MODE_SCREEN:   return 255 - round_div255((255 - a) * (255 - b));
      MODE_OVERLAY: begin
        if (a < 128) return round_div255(2 * a * b);
        return 255 - round_div255(2 * (255 - a) * (255 - b));
      end
      MODE_DIFF:     return (a >= b) ? a - b : b - a;
      // unused codes pass the base through
      default:       return a;
    endcase
  endfunction

  // opacity mix with the base, rounding half up
  function automatic logic [ChanW-1:0] opacity_mix(input int unsigned a,
                                                   input int unsigned b);
    int unsigned w;
    int unsigned f;
    int unsigned mix;
    w   = cur_opacity;
    f   = mode_blend(cur_mode, a, b);
    mix = w * f + (256 - w) * a + 128;
    return mix[15:8];
  endfunction

  function automatic pixel_t predict_pixel();
    pixel_t px;
    px.red   = opacity_mix(base_red_i,   top_red_i);
    px.green = opacity_mix(base_green_i, top_green_i);
    px.blue  = opacity_mix(base_blue_i,  top_blue_i);
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_px;
    if (!rst_ni) begin
      cur_mode    = MODE_NORMAL;
      cur_opacity = FullWeight;
      blended_px_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      result_idx   = 0;
    end else begin
      // result word against the oldest prediction
      if (out_valid_i) begin
        if (blended_px_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result %0d with no pixel pending: %0d %0d %0d", $realtime,
                     result_idx, out_red_i, out_green_i, out_blue_i);
        end else begin
          exp_px = blended_px_q.pop_front();
          if (out_red_i !== exp_px.red || out_green_i !== exp_px.green ||
              out_blue_i !== exp_px.blue) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: result %0d expected rgb %0d %0d %0d, got %0d %0d %0d",
                       $realtime, result_idx, exp_px.red, exp_px.green, exp_px.blue,
                       out_red_i, out_green_i, out_blue_i);
          end
        end
        result_idx++;
      end
      // accepted pixel pair, blended with the settings held before this edge
      if (start_i && !busy_i) blended_px_q.push_back(predict_pixel());
      pending_o = blended_px_q.size();
      // register writes, opacity saturates at full weight
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          REG_MODE:    cur_mode = pwdata_i[ModeW-1:0];
          REG_OPACITY: cur_opacity = (pwdata_i[WeightW-1:0] > FullWeight) ?
                                     FullWeight : pwdata_i[WeightW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/pixel_blend_modes_opacity_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_blend_modes_opacity_top_tb
// Drives pixel pairs and register writes into the blend block: a directed
// pass over every mode code, channel extremes and opacity corners, then
// random pixels under random mode and opacity settings with sender gaps.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module pixel_blend_modes_opacity_top_tb;
  import pbm_pkg::*;

  localparam int PixelsPerPhase = 70;
  localparam int NumPhases      = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [ChanW-1:0] base_red, base_green, base_blue;
  logic [ChanW-1:0] top_red, top_green, top_blue;
  logic             out_valid;
  logic [ChanW-1:0] out_red, out_green, out_blue;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int               fail_count;
  int               pending;
  int               gap_pct;

  pixel_blend_modes_opacity_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .base_red_i   (base_red),
    .base_green_i (base_green),
    .base_blue_i  (base_blue),
    .top_red_i    (top_red),
    .top_green_i  (top_green),
    .top_blue_i   (top_blue),
    .out_valid_o  (out_valid),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  pbm_blend_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .base_red_i   (base_red),
    .base_green_i (base_green),
    .base_blue_i  (base_blue),
    .top_red_i    (top_red),
    .top_green_i  (top_green),
    .top_blue_i   (top_blue),
    .out_valid_i  (out_valid),
    .out_red_i    (out_red),
    .out_green_i  (out_green),
    .out_blue_i   (out_blue),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("pixel_blend_modes_opacity_top_tb NOT OK");
    $finish;
  end

  // byte biased toward the channel extremes
  function automatic logic [ChanW-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(255);
    endcase
  endfunction

  // register write with a setup phase followed by an access phase
  task automatic reg_write(input reg_idx_e idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one pixel pair word, with random sender gaps ahead of it
  task automatic send_pixel(input logic [ChanW-1:0] br, input logic [ChanW-1:0] bg,
                            input logic [ChanW-1:0] bb, input logic [ChanW-1:0] tr,
                            input logic [ChanW-1:0] tg, input logic [ChanW-1:0] tb);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    base_red   <= br;
    base_green <= bg;
    base_blue  <= bb;
    top_red    <= tr;
    top_green  <= tg;
    top_blue   <= tb;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_byte(), pick_byte(), pick_byte(),
               pick_byte(), pick_byte(), pick_byte());
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // the two directed pixel pairs: extremes and the overlay switch point
  task automatic send_corner_pixels();
    send_pixel(8'd0, 8'd127, 8'd255, 8'd255, 8'd128, 8'd0);
    send_pixel(8'd128, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255);
  endtask

  initial begin
    logic [ModeW-1:0]   mode;
    logic [WeightW-1:0] weight;
    rst_ni     = 1'b0;
    start      = 1'b0;
    base_red   = '0;
    base_green = '0;
    base_blue  = '0;
    top_red    = '0;
    top_green  = '0;
    top_blue   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gap_pct    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every mode code at full opacity, unused codes included
    for (int m = 0; m < (1 << ModeW); m++) begin
      reg_write(REG_MODE, m);
      send_corner_pixels();
      drain();
    end
    // directed: opacity zero, above full scale, and half way
    reg_write(REG_MODE, MODE_OVERLAY);
    reg_write(REG_OPACITY, 0);
    send_corner_pixels();
    drain();
    reg_write(REG_OPACITY, 300);
    send_corner_pixels();
    drain();
    reg_write(REG_MODE, MODE_SCREEN);
    reg_write(REG_OPACITY, 128);
    send_corner_pixels();
    drain();

    // random: new settings per phase, sender gaps 33, then 53, then none
    for (int ph = 0; ph < NumPhases; ph++) begin
      gap_pct = (ph < 4) ? 33 : (ph < 7) ? 53 : 0;
      mode    = $urandom_range((1 << ModeW) - 1);
      case ($urandom_range(4))
        0:       weight = '0;
        1:       weight = FullWeight;
        2:       weight = $urandom_range(511, 257);
        default: weight = $urandom_range(255, 1);
      endcase
      // upper data bits are noise the block must mask off
      reg_write(REG_MODE, ($urandom() & ~32'h7) | mode);
      reg_write(REG_OPACITY, ($urandom() & ~32'h1ff) | weight);
      repeat (PixelsPerPhase) send_random_pixel();
      drain();
    end

    repeat (NumStages + 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_blend_modes_opacity_top_tb OK");
    end else begin
      $display("pixel_blend_modes_opacity_top_tb NOT OK");
    end
    $finish;
  end

endmodule
